// ===== rtl/core/rldm_pkg.sv =====
package rldm_pkg;

  localparam int MAX_ITERATIONS = 50;
  localparam int COORD_WIDTH    = 32;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 48;
  localparam int TOL_LSB        = 16;
  localparam int CENTER_RR_TOL  = 281;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_K0  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_K1  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_K2  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_K3  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_K4  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 8'd7;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_FWD,
    KIND_INV
  } kind_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic               converged;
  } out_item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } job_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [47:0] k0;
    logic signed [47:0] k1;
    logic signed [47:0] k2;
    logic signed [47:0] k3;
    logic signed [47:0] k4;
    logic               enable;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MAG,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_MPREP,
    ST_MLO,
    ST_MHI,
    ST_MRND,
    ST_HADD,
    ST_AUPD,
    ST_CHECK,
    ST_OUT
  } back_state_t;

endpackage

// ===== rtl/core/rldm_front.sv =====
module rldm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              enable,
  input  logic              in_valid,
  output logic              in_ready,
  input  rldm_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output rldm_pkg::job_t    q_job
);

  rldm_pkg::job_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  rldm_pkg::job_t job_in;
  logic           push, pop;

  // Classify the incoming request
  always_comb begin
    job_in.x = in_data.point_x;
    job_in.y = in_data.point_y;
    if (!enable) begin
      job_in.kind = rldm_pkg::KIND_PASS;
    end else if (in_data.req_type) begin
      job_in.kind = rldm_pkg::KIND_INV;
    end else begin
      job_in.kind = rldm_pkg::KIND_FWD;
    end
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_job    = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Advance queue pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

// ===== rtl/core/rldm_isqrt.sv =====
module rldm_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  rldm_pkg::sqrt_req_t req,
  output rldm_pkg::sqrt_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] v_r, v_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [35:0] rem_s, trial;

  // One result bit per cycle, restoring method
  always_comb begin
    rem_s     = {rem_r[33:0], v_r[63:62]};
    trial     = {2'b00, root_r, 2'b01};
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    v_nxt     = v_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      v_nxt    = req.radicand;
      rem_nxt  = 36'd0;
      root_nxt = 32'd0;
    end else if (busy_r) begin
      v_nxt = {v_r[61:0], 2'b00};
      if (rem_s >= trial) begin
        rem_nxt  = rem_s - trial;
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_s;
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

// ===== rtl/core/rldm_back.sv =====
module rldm_back #(
  parameter int MAX_ITERATIONS = rldm_pkg::MAX_ITERATIONS,
  parameter int COORD_WIDTH    = rldm_pkg::COORD_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rldm_pkg::cfg_t     cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  rldm_pkg::job_t     q_job,
  output logic               out_valid,
  input  logic               out_ready,
  output rldm_pkg::out_item_t out_data
);

  localparam int XW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam int IW = $clog2(MAX_ITERATIONS + 1);
  localparam logic [IW-1:0] ITER_LAST = IW'(MAX_ITERATIONS - 1);
  localparam logic signed [64:0] S32_MAX = 65'sd2147483647;
  localparam logic signed [64:0] S32_MIN = -65'sd2147483648;
  localparam logic signed [64:0] CW_MAX  = (65'sd1 <<< (COORD_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] CW_MIN  = -CW_MAX - 65'sd1;
  localparam logic signed [64:0] TOL_P   = 65'(rldm_pkg::TOL_LSB);
  localparam logic signed [64:0] TOL_N   = -65'(rldm_pkg::TOL_LSB);
  localparam logic [63:0] RR_TOL = 64'(rldm_pkg::CENTER_RR_TOL);
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  rldm_pkg::back_state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  rldm_pkg::out_item_t out_data_r, out_data_nxt;

  rldm_pkg::kind_t    kind_r, kind_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [XW-1:0] xt_r, xt_nxt, yt_r, yt_nxt;
  logic signed [XW-1:0] xp_r, xp_nxt, yp_r, yp_nxt;
  logic signed [XW-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [IW-1:0]      iter_r, iter_nxt;
  logic signed [31:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [31:0]        mx_r, mx_nxt, my_r, my_nxt;
  logic [63:0]        rr_r, rr_nxt;
  logic [31:0]        r_r, r_nxt;
  logic signed [63:0] s_r, s_nxt;
  logic [1:0]         ki_r, ki_nxt;
  logic               apply_r, apply_nxt;
  logic               axis_r, axis_nxt;
  logic [63:0]        ua_r, ua_nxt;
  logic [31:0]        ub_r, ub_nxt;
  logic               neg_r, neg_nxt;
  logic [95:0]        prod_r, prod_nxt;
  logic signed [63:0] mres_r, mres_nxt;
  logic signed [31:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic               conv_r, conv_nxt;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic signed [64:0] dx_w, dy_w, t_w, sat_w, dxp_w, dyp_w;
  logic [63:0]        rr_sum;
  logic [96:0]        rnd_w, shf_w;
  logic signed [63:0] k_sel;
  logic               close;

  rldm_pkg::sqrt_req_t sq_req;
  rldm_pkg::sqrt_rsp_t sq_rsp;

  rldm_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  // Shared 32x32 multiplier
  always_comb begin
    unique case (state_r)
      rldm_pkg::ST_SQ_X: begin
        mul_a = mx_r;
        mul_b = mx_r;
      end
      rldm_pkg::ST_SQ_Y: begin
        mul_a = my_r;
        mul_b = my_r;
      end
      rldm_pkg::ST_MHI: begin
        mul_a = ua_r[63:32];
        mul_b = ub_r;
      end
      default: begin
        mul_a = ua_r[31:0];
        mul_b = ub_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Coefficient for the current Horner step
  always_comb begin
    unique case (ki_r)
      2'd3:    k_sel = 64'($signed(cfg.k3));
      2'd2:    k_sel = 64'($signed(cfg.k2));
      2'd1:    k_sel = 64'($signed(cfg.k1));
      default: k_sel = 64'($signed(cfg.k0));
    endcase
  end

  // Sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    kind_nxt      = kind_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    xt_nxt        = xt_r;
    yt_nxt        = yt_r;
    xp_nxt        = xp_r;
    yp_nxt        = yp_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    have_prev_nxt = have_prev_r;
    iter_nxt      = iter_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    rr_nxt        = rr_r;
    r_nxt         = r_r;
    s_nxt         = s_r;
    ki_nxt        = ki_r;
    apply_nxt     = apply_r;
    axis_nxt      = axis_r;
    ua_nxt        = ua_r;
    ub_nxt        = ub_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    mres_nxt      = mres_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    conv_nxt      = conv_r;
    q_ready       = 1'b0;
    sq_req.start    = 1'b0;
    sq_req.radicand = rr_r;
    dx_w  = 65'(xt_r) - 65'($signed(cfg.center_x));
    dy_w  = 65'(yt_r) - 65'($signed(cfg.center_y));
    rr_sum = rr_r + mul_p;
    rnd_w = {1'b0, prod_r} + (neg_r ? 97'd0 : 97'd0) +
            (apply_r ? (97'd1 << 43) : (97'd1 << 23));
    shf_w = apply_r ? (rnd_w >> 44) : (rnd_w >> 24);
    t_w   = 65'sd0;
    sat_w = 65'sd0;
    dxp_w = 65'(nx_r) - 65'(xp_r);
    dyp_w = 65'(ny_r) - 65'(yp_r);
    close = have_prev_r && (dxp_w <= TOL_P) && (dxp_w >= TOL_N) &&
            (dyp_w <= TOL_P) && (dyp_w >= TOL_N);

    unique case (state_r)
      rldm_pkg::ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          kind_nxt      = q_job.kind;
          px_nxt        = q_job.x;
          py_nxt        = q_job.y;
          xt_nxt        = XW'(q_job.x);
          yt_nxt        = XW'(q_job.y);
          have_prev_nxt = 1'b0;
          iter_nxt      = '0;
          conv_nxt      = 1'b1;
          res_x_nxt     = q_job.x;
          res_y_nxt     = q_job.y;
          if (q_job.kind == rldm_pkg::KIND_PASS) begin
            state_nxt = rldm_pkg::ST_OUT;
          end else begin
            state_nxt = rldm_pkg::ST_DELTA;
          end
        end
      end
      // Offset from centre, clipped to 32 bits
      rldm_pkg::ST_DELTA: begin
        ex_nxt = (dx_w > S32_MAX) ? 32'sh7FFF_FFFF :
                 (dx_w < S32_MIN) ? 32'sh8000_0000 : dx_w[31:0];
        ey_nxt = (dy_w > S32_MAX) ? 32'sh7FFF_FFFF :
                 (dy_w < S32_MIN) ? 32'sh8000_0000 : dy_w[31:0];
        state_nxt = rldm_pkg::ST_MAG;
      end
      rldm_pkg::ST_MAG: begin
        mx_nxt    = ex_r[31] ? (~ex_r + 32'd1) : ex_r;
        my_nxt    = ey_r[31] ? (~ey_r + 32'd1) : ey_r;
        state_nxt = rldm_pkg::ST_SQ_X;
      end
      rldm_pkg::ST_SQ_X: begin
        rr_nxt    = mul_p;
        state_nxt = rldm_pkg::ST_SQ_Y;
      end
      // Finish the squared radius; forward points near the centre pass through unchanged
      rldm_pkg::ST_SQ_Y: begin
        rr_nxt = rr_sum;
        if (kind_r == rldm_pkg::KIND_FWD && rr_sum <= RR_TOL) begin
          state_nxt = rldm_pkg::ST_OUT;
        end else begin
          state_nxt = rldm_pkg::ST_SQRT_GO;
        end
      end
      rldm_pkg::ST_SQRT_GO: begin
        sq_req.start = 1'b1;
        state_nxt    = rldm_pkg::ST_SQRT_WAIT;
      end
      rldm_pkg::ST_SQRT_WAIT: begin
        if (sq_rsp.done) begin
          r_nxt     = sq_rsp.root;
          s_nxt     = 64'($signed(cfg.k4));
          ki_nxt    = 2'd3;
          apply_nxt = 1'b0;
          axis_nxt  = 1'b0;
          state_nxt = rldm_pkg::ST_MPREP;
        end
      end
      // Load sign and magnitudes for the next product
      rldm_pkg::ST_MPREP: begin
        ua_nxt    = s_r[63] ? (~s_r + 64'd1) : s_r;
        ub_nxt    = apply_r ? (axis_r ? my_r : mx_r) : r_r;
        neg_nxt   = s_r[63] ^ (apply_r && (axis_r ? ey_r[31] : ex_r[31]));
        state_nxt = rldm_pkg::ST_MLO;
      end
      rldm_pkg::ST_MLO: begin
        prod_nxt  = 96'(mul_p);
        state_nxt = rldm_pkg::ST_MHI;
      end
      rldm_pkg::ST_MHI: begin
        prod_nxt  = prod_r + {mul_p, 32'd0};
        state_nxt = rldm_pkg::ST_MRND;
      end
      // Round to nearest, shift and saturate the product
      rldm_pkg::ST_MRND: begin
        if (neg_r) begin
          mres_nxt = (|shf_w[96:63]) ? S64_MIN : (~shf_w[63:0] + 64'd1);
        end else begin
          mres_nxt = (|shf_w[96:63]) ? S64_MAX : shf_w[63:0];
        end
        state_nxt = apply_r ? rldm_pkg::ST_AUPD : rldm_pkg::ST_HADD;
      end
      rldm_pkg::ST_HADD: begin
        t_w = 65'(mres_r) + 65'(k_sel);
        if (t_w[64] != t_w[63]) begin
          s_nxt = t_w[64] ? S64_MIN : S64_MAX;
        end else begin
          s_nxt = t_w[63:0];
        end
        if (ki_r == 2'd0) begin
          apply_nxt = 1'b1;
          axis_nxt  = 1'b0;
        end else begin
          ki_nxt = ki_r - 2'd1;
        end
        state_nxt = rldm_pkg::ST_MPREP;
      end
      // Apply the distortion to one axis
      rldm_pkg::ST_AUPD: begin
        if (kind_r == rldm_pkg::KIND_FWD) begin
          t_w   = 65'(axis_r ? py_r : px_r) + 65'(mres_r);
          sat_w = (t_w > S32_MAX) ? S32_MAX : (t_w < S32_MIN) ? S32_MIN : t_w;
          if (axis_r) begin
            res_y_nxt = sat_w[31:0];
          end else begin
            res_x_nxt = sat_w[31:0];
          end
        end else begin
          t_w   = 65'(axis_r ? py_r : px_r) - 65'(mres_r);
          sat_w = (t_w > CW_MAX) ? CW_MAX : (t_w < CW_MIN) ? CW_MIN : t_w;
          if (axis_r) begin
            ny_nxt = sat_w[XW-1:0];
          end else begin
            nx_nxt = sat_w[XW-1:0];
          end
        end
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = rldm_pkg::ST_MPREP;
        end else if (kind_r == rldm_pkg::KIND_FWD) begin
          state_nxt = rldm_pkg::ST_OUT;
        end else begin
          state_nxt = rldm_pkg::ST_CHECK;
        end
      end
      // Convergence test and iteration limit
      rldm_pkg::ST_CHECK: begin
        xt_nxt = nx_r;
        yt_nxt = ny_r;
        t_w    = 65'(nx_r);
        sat_w  = (t_w > S32_MAX) ? S32_MAX : (t_w < S32_MIN) ? S32_MIN : t_w;
        res_x_nxt = sat_w[31:0];
        t_w    = 65'(ny_r);
        sat_w  = (t_w > S32_MAX) ? S32_MAX : (t_w < S32_MIN) ? S32_MIN : t_w;
        res_y_nxt = sat_w[31:0];
        if (close) begin
          conv_nxt  = 1'b1;
          state_nxt = rldm_pkg::ST_OUT;
        end else begin
          xp_nxt        = nx_r;
          yp_nxt        = ny_r;
          have_prev_nxt = 1'b1;
          if (iter_r == ITER_LAST) begin
            conv_nxt  = 1'b0;
            state_nxt = rldm_pkg::ST_OUT;
          end else begin
            iter_nxt  = iter_r + IW'(1);
            state_nxt = rldm_pkg::ST_DELTA;
          end
        end
      end
      // Hand the result to the output register
      rldm_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.result_x  = res_x_r;
          out_data_nxt.result_y  = res_y_r;
          out_data_nxt.converged = conv_r;
          state_nxt              = rldm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rldm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rldm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    kind_r      <= kind_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    xt_r        <= xt_nxt;
    yt_r        <= yt_nxt;
    xp_r        <= xp_nxt;
    yp_r        <= yp_nxt;
    nx_r        <= nx_nxt;
    ny_r        <= ny_nxt;
    have_prev_r <= have_prev_nxt;
    iter_r      <= iter_nxt;
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    mx_r        <= mx_nxt;
    my_r        <= my_nxt;
    rr_r        <= rr_nxt;
    r_r         <= r_nxt;
    s_r         <= s_nxt;
    ki_r        <= ki_nxt;
    apply_r     <= apply_nxt;
    axis_r      <= axis_nxt;
    ua_r        <= ua_nxt;
    ub_r        <= ub_nxt;
    neg_r       <= neg_nxt;
    prod_r      <= prod_nxt;
    mres_r      <= mres_nxt;
    res_x_r     <= res_x_nxt;
    res_y_r     <= res_y_nxt;
    conv_r      <= conv_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/radial_lens_distortion_map_core.sv =====
// Pass-through items go straight to the output stage; forward items near the centre
// skip the square root, and inverse items iterate for up to MAX_ITERATIONS rounds.
// One item in the back end at a time; a two-entry queue holds further items.
// Per item cost is set by the 32-step bit-serial square root and the shared
// 32x32 multiplier, two passes per 64-bit product. Synchronous reset (rst_n)
// empties the queue, idles the sequencer, drops out_valid and zeroes the config.
module radial_lens_distortion_map_core #(
  parameter int MAX_ITERATIONS = rldm_pkg::MAX_ITERATIONS,
  parameter int COORD_WIDTH    = rldm_pkg::COORD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rldm_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rldm_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rldm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rldm_pkg::CFG_DATA_W-1:0] cfg_data
);

  rldm_pkg::cfg_t cfg_r, cfg_nxt;
  logic           q_valid, q_ready;
  rldm_pkg::job_t q_job;

  assign cfg_ready = 1'b1;

  // Register file write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rldm_pkg::REG_CENTER_X: cfg_nxt.center_x = cfg_data[31:0];
        rldm_pkg::REG_CENTER_Y: cfg_nxt.center_y = cfg_data[31:0];
        rldm_pkg::REG_COEF_K0:  cfg_nxt.k0       = cfg_data;
        rldm_pkg::REG_COEF_K1:  cfg_nxt.k1       = cfg_data;
        rldm_pkg::REG_COEF_K2:  cfg_nxt.k2       = cfg_data;
        rldm_pkg::REG_COEF_K3:  cfg_nxt.k3       = cfg_data;
        rldm_pkg::REG_COEF_K4:  cfg_nxt.k4       = cfg_data;
        rldm_pkg::REG_ENABLE:   cfg_nxt.enable   = cfg_data[0];
        default:                cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rldm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .enable   (cfg_r.enable),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_job    (q_job)
  );

  rldm_back #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .COORD_WIDTH    (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_job     (q_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
